// ===== src/ipi_pkg.sv =====
// Shared constants, types and helpers of the I/Q power integrator.
package ipi_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned FFT_W     = 17;
  localparam int unsigned ACC_W     = 55;
  localparam int unsigned SQ_W      = 2 * SAMPLE_W - 1;
  localparam int unsigned PWR_W     = 2 * SAMPLE_W;
  localparam int unsigned BLK_W     = 20;
  localparam int unsigned RATIO_W   = 36;
  localparam int unsigned Q_W       = FRAC_W + 1;
  localparam int unsigned DIV_W     = RATIO_W + 2;
  localparam int unsigned NUM_W     = 76;
  localparam int unsigned OUT_W     = 63;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RNUM_W    = COUNT_W + FRAC_W;
  localparam int unsigned RSTEP_W   = 6;
  localparam int unsigned MAC_LO_W  = 28;
  localparam int unsigned MAC_HI_W  = ACC_W - MAC_LO_W;
  localparam int unsigned PROD_W    = MAC_LO_W + Q_W;
  localparam int unsigned DSTEP_W   = 7;
  localparam int unsigned MSTEP_W   = 3;
  localparam int unsigned MAC_STEPS = 4;

  localparam logic [FFT_W-1:0] FFT_MIN   = 17'd16;
  localparam logic [FFT_W-1:0] FFT_MAX   = 17'h10000;
  localparam logic [FFT_W-1:0] FFT_RESET = 17'd1024;
  localparam logic [Q_W-1:0]   ONE_Q     = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEGRATE = 2'd0,
    REG_FFT       = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic             is_time;
    logic [ACC_W-1:0] e_prev;
    logic [ACC_W-1:0] e_whole;
    logic [ACC_W-1:0] e_next;
    logic [Q_W-1:0]   alpha;
    logic [Q_W-1:0]   beta;
    logic [DIV_W-1:0] divisor;
  } job_t;

  function automatic logic [FFT_W-1:0] clamp_fft(input logic [FFT_W-1:0] raw);
    if (raw < FFT_MIN) begin
      return FFT_MIN;
    end
    if (raw > FFT_MAX) begin
      return FFT_MAX;
    end
    return raw;
  endfunction

endpackage

// ===== src/iq_power_integrator_unit.sv =====
// Top level of the I/Q power integrator.
//  channel   direction  handshake                  payload
//  cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//  sample    in         in_valid_i / in_stall_o    sample_re_i, sample_im_i
//  power     out        out_valid_o / out_stall_i  average_power_o
// Samples enter at one per cycle unless in_stall_o holds them; each one passes
// through the squaring and accumulation stages. A finished window goes through the
// back end as pop, multiply-accumulate, divide and output; time mode skips the MAC.
// A two-entry job queue absorbs windows; input stalls when a window ends on a full queue.
// A config write runs a serial ratio divide with input and config held off.
// Reset is asynchronous and active low; no clearing pass follows it.
module iq_power_integrator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ipi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ipi_pkg::COUNT_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ipi_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [ipi_pkg::SAMPLE_W-1:0] sample_im_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ipi_pkg::OUT_W-1:0]         average_power_o
);

  ipi_pkg::job_t push_job, pop_job;
  logic          push, full, pop, empty;

  ipi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  ipi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  ipi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (pop_job),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .average_power_o (average_power_o)
  );

endmodule

// ===== src/ipi_front.sv =====
// Front end: config registers, ratio divider, squaring and window accumulation.
module ipi_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ipi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ipi_pkg::COUNT_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ipi_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [ipi_pkg::SAMPLE_W-1:0] sample_im_i,
  output logic                            push_o,
  output ipi_pkg::job_t                   job_o,
  input  logic                            full_i
);

  logic [ipi_pkg::COUNT_W-1:0]  n_q, n_d;
  logic [ipi_pkg::FFT_W-1:0]    fft_q, fft_d, fs;
  logic                         rbusy_q, rbusy_d;
  logic [ipi_pkg::RSTEP_W-1:0]  rcnt_q, rcnt_d;
  logic [ipi_pkg::RNUM_W-1:0]   rnum_q, rnum_d;
  logic [ipi_pkg::FFT_W-1:0]    rrem_q, rrem_d;
  logic [ipi_pkg::FFT_W:0]      rem_sh, rem_diff;
  logic                         r_ge;
  logic [ipi_pkg::RATIO_W-1:0]  ratio_q, ratio_d, kr_q, kr_d, beta_ext;
  logic [ipi_pkg::DIV_W-1:0]    div3;
  logic                         s1_valid_q, s1_valid_d;
  logic [ipi_pkg::SQ_W-1:0]     sqr_q, sqi_q;
  logic signed [ipi_pkg::PWR_W-1:0] re_sq, im_sq;
  logic [ipi_pkg::ACC_W-1:0]    acc_q, acc_d, acc_sum;
  logic [ipi_pkg::ACC_W:0]      sum;
  logic [ipi_pkg::PWR_W-1:0]    pwr;
  logic [ipi_pkg::FFT_W-1:0]    bin_q, bin_d, bin_inc;
  logic [ipi_pkg::BLK_W-1:0]    blk_q, blk_d, nb_q, nb_d, nb;
  logic [ipi_pkg::BLK_W:0]      blk_inc;
  logic [ipi_pkg::ACC_W-1:0]    e_whole_q, e_whole_d, e_prev_q, e_prev_d;
  logic [ipi_pkg::Q_W-1:0]      alpha_q, alpha_d, beta_q, beta_d, beta_new;
  logic                         cfg_hit, accept, time_mode, active, start, wrap;
  logic                         hit_whole, hit_end, t_end, push_need, blocked, proc;

  assign fs          = ipi_pkg::clamp_fft(fft_q);
  assign cfg_ready_o = !rbusy_q;
  assign cfg_hit     = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i == ipi_pkg::REG_INTEGRATE ||
                        cfg_index_i == ipi_pkg::REG_FFT);

  assign re_sq = sample_re_i * sample_re_i;
  assign im_sq = sample_im_i * sample_im_i;

  assign pwr     = {1'b0, sqr_q} + {1'b0, sqi_q};
  assign sum     = {1'b0, acc_q} + (ipi_pkg::ACC_W + 1)'(pwr);
  assign acc_sum = sum[ipi_pkg::ACC_W] ? '1 : sum[ipi_pkg::ACC_W-1:0];

  assign time_mode = n_q < ipi_pkg::COUNT_W'(fs);
  assign active    = n_q != '0;
  assign start     = (bin_q == '0) && (blk_q == '0);
  assign nb        = start ? kr_q[ipi_pkg::RATIO_W-1:ipi_pkg::FRAC_W] : nb_q;
  assign bin_inc   = bin_q + 1'b1;
  assign blk_inc   = {1'b0, blk_q} + 1'b1;
  assign wrap      = bin_inc == fs;
  assign hit_whole = wrap && (blk_inc == {1'b0, nb});
  assign hit_end   = wrap && (blk_inc == ({1'b0, nb} + 1'b1));
  assign t_end     = bin_inc == n_q[ipi_pkg::FFT_W-1:0];
  assign push_need = active && (time_mode ? t_end : hit_end);
  assign blocked   = s1_valid_q && push_need && full_i;
  assign proc      = s1_valid_q && !blocked;
  assign in_stall_o = rbusy_q || blocked;
  assign accept    = in_valid_i && !in_stall_o;

  assign div3     = {2'b0, ratio_q} + {1'b0, ratio_q, 1'b0};
  assign beta_new = ipi_pkg::ONE_Q - alpha_q;
  assign beta_ext = ipi_pkg::RATIO_W'(beta_new);

  assign rem_sh   = {rrem_q, rnum_q[ipi_pkg::RNUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, fs};
  assign r_ge     = rem_sh >= {1'b0, fs};

  always_comb begin
    n_d       = n_q;
    fft_d     = fft_q;
    rbusy_d   = rbusy_q;
    rcnt_d    = rcnt_q;
    rnum_d    = rnum_q;
    rrem_d    = rrem_q;
    ratio_d   = ratio_q;
    kr_d      = kr_q;
    acc_d     = acc_q;
    bin_d     = bin_q;
    blk_d     = blk_q;
    nb_d      = nb_q;
    e_whole_d = e_whole_q;
    e_prev_d  = e_prev_q;
    alpha_d   = alpha_q;
    beta_d    = beta_q;
    push_o    = 1'b0;
    job_o     = '0;
    s1_valid_d = accept || blocked;

    if (rbusy_q) begin
      rrem_d = r_ge ? rem_diff[ipi_pkg::FFT_W-1:0] : rem_sh[ipi_pkg::FFT_W-1:0];
      rnum_d = {rnum_q[ipi_pkg::RNUM_W-2:0], r_ge};
      rcnt_d = rcnt_q + 1'b1;
      if (rcnt_q == ipi_pkg::RSTEP_W'(ipi_pkg::RNUM_W - 1)) begin
        rbusy_d = 1'b0;
        ratio_d = rnum_d[ipi_pkg::RATIO_W-1:0];
        kr_d    = rnum_d[ipi_pkg::RATIO_W-1:0];
      end
    end

    if (proc && active) begin
      if (time_mode) begin
        if (t_end) begin
          push_o        = 1'b1;
          job_o.is_time = 1'b1;
          job_o.e_next  = acc_sum;
          job_o.divisor = ipi_pkg::DIV_W'(n_q);
          acc_d = '0;
          bin_d = '0;
        end else begin
          acc_d = acc_sum;
          bin_d = bin_inc;
        end
      end else begin
        if (start) begin
          alpha_d   = {1'b0, kr_q[ipi_pkg::FRAC_W-1:0]};
          nb_d      = kr_q[ipi_pkg::RATIO_W-1:ipi_pkg::FRAC_W];
          e_whole_d = '0;
        end
        acc_d = acc_sum;
        bin_d = wrap ? '0 : bin_inc;
        blk_d = wrap ? blk_inc[ipi_pkg::BLK_W-1:0] : blk_q;
        if (hit_whole) begin
          e_whole_d = acc_sum;
          acc_d     = '0;
        end else if (hit_end) begin
          push_o        = 1'b1;
          job_o.e_prev  = e_prev_q;
          job_o.e_whole = e_whole_q;
          job_o.e_next  = acc_sum;
          job_o.alpha   = alpha_q;
          job_o.beta    = beta_q;
          job_o.divisor = div3;
          e_prev_d = acc_sum;
          beta_d   = beta_new;
          kr_d     = (ratio_q >= beta_ext) ? ratio_q - beta_ext : '0;
          acc_d    = '0;
          bin_d    = '0;
          blk_d    = '0;
        end
      end
    end

    if (cfg_hit) begin
      if (cfg_index_i == ipi_pkg::REG_INTEGRATE) begin
        n_d = cfg_data_i;
      end else begin
        fft_d = cfg_data_i[ipi_pkg::FFT_W-1:0];
      end
      rbusy_d   = 1'b1;
      rcnt_d    = '0;
      rrem_d    = '0;
      rnum_d    = {n_d, ipi_pkg::FRAC_W'(0)};
      acc_d     = '0;
      bin_d     = '0;
      blk_d     = '0;
      nb_d      = '0;
      e_whole_d = '0;
      e_prev_d  = '0;
      alpha_d   = '0;
      beta_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      fft_q      <= ipi_pkg::FFT_RESET;
      rbusy_q    <= 1'b0;
      rcnt_q     <= '0;
      rnum_q     <= '0;
      rrem_q     <= '0;
      ratio_q    <= '0;
      kr_q       <= '0;
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      bin_q      <= '0;
      blk_q      <= '0;
      nb_q       <= '0;
      e_whole_q  <= '0;
      e_prev_q   <= '0;
      alpha_q    <= '0;
      beta_q     <= '0;
    end else begin
      n_q        <= n_d;
      fft_q      <= fft_d;
      rbusy_q    <= rbusy_d;
      rcnt_q     <= rcnt_d;
      rnum_q     <= rnum_d;
      rrem_q     <= rrem_d;
      ratio_q    <= ratio_d;
      kr_q       <= kr_d;
      s1_valid_q <= s1_valid_d;
      acc_q      <= acc_d;
      bin_q      <= bin_d;
      blk_q      <= blk_d;
      nb_q       <= nb_d;
      e_whole_q  <= e_whole_d;
      e_prev_q   <= e_prev_d;
      alpha_q    <= alpha_d;
      beta_q     <= beta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sqr_q <= re_sq[ipi_pkg::SQ_W-1:0];
      sqi_q <= im_sq[ipi_pkg::SQ_W-1:0];
    end
  end

endmodule

// ===== src/ipi_queue.sv =====
// Two-entry job queue between the front and back ends.
module ipi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipi_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output ipi_pkg::job_t job_o,
  output logic          empty_o
);

  ipi_pkg::job_t mem_q [2];
  logic          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== src/ipi_back.sv =====
// Back end: numerator multiply-accumulate, serial divider and output register.
module ipi_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ipi_pkg::job_t              job_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ipi_pkg::OUT_W-1:0]  average_power_o
);

  ipi_pkg::back_state_e         state_q, state_d;
  ipi_pkg::job_t                job_q, job_d;
  logic [ipi_pkg::NUM_W-1:0]    num_q, num_d, addend, num_sum;
  logic [ipi_pkg::DIV_W-1:0]    div_q, div_d, rem_q, rem_d;
  logic [ipi_pkg::DIV_W:0]      rem_sh, rem_diff;
  logic                         ge;
  logic [ipi_pkg::DSTEP_W-1:0]  dstep_q, dstep_d;
  logic [ipi_pkg::MSTEP_W-1:0]  mstep_q, mstep_d;
  logic [ipi_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic                         pv_q, pv_d, psh_q, psh_d;
  logic [ipi_pkg::MAC_LO_W-1:0] mac_a;
  logic [ipi_pkg::Q_W-1:0]      mac_b;
  logic                         mac_sh;
  logic [ipi_pkg::OUT_W-1:0]    out_q, out_d;

  assign out_valid_o     = state_q == ipi_pkg::BK_OUT;
  assign average_power_o = out_q;

  assign addend   = psh_q ? (ipi_pkg::NUM_W'(prod_q) << ipi_pkg::MAC_LO_W)
                          : ipi_pkg::NUM_W'(prod_q);
  assign num_sum  = pv_q ? num_q + addend : num_q;
  assign rem_sh   = {rem_q, num_q[ipi_pkg::NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign ge       = rem_sh >= {1'b0, div_q};

  always_comb begin
    case (mstep_q)
      3'd0: begin
        mac_a  = job_q.e_prev[ipi_pkg::MAC_LO_W-1:0];
        mac_b  = job_q.beta;
        mac_sh = 1'b0;
      end
      3'd1: begin
        mac_a  = ipi_pkg::MAC_LO_W'(job_q.e_prev[ipi_pkg::ACC_W-1:ipi_pkg::MAC_LO_W]);
        mac_b  = job_q.beta;
        mac_sh = 1'b1;
      end
      3'd2: begin
        mac_a  = job_q.e_next[ipi_pkg::MAC_LO_W-1:0];
        mac_b  = job_q.alpha;
        mac_sh = 1'b0;
      end
      3'd3: begin
        mac_a  = ipi_pkg::MAC_LO_W'(job_q.e_next[ipi_pkg::ACC_W-1:ipi_pkg::MAC_LO_W]);
        mac_b  = job_q.alpha;
        mac_sh = 1'b1;
      end
      default: begin
        mac_a  = '0;
        mac_b  = '0;
        mac_sh = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    dstep_d = dstep_q;
    mstep_d = mstep_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    prod_d  = mac_a * mac_b;
    psh_d   = mac_sh;
    pv_d    = 1'b0;
    unique case (state_q)
      ipi_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          div_d   = job_i.divisor;
          rem_d   = '0;
          dstep_d = '0;
          mstep_d = '0;
          if (job_i.is_time) begin
            num_d   = ipi_pkg::NUM_W'(job_i.e_next);
            state_d = ipi_pkg::BK_DIV;
          end else begin
            num_d   = ipi_pkg::NUM_W'({job_i.e_whole, ipi_pkg::FRAC_W'(0)});
            state_d = ipi_pkg::BK_MAC;
          end
        end
      end
      ipi_pkg::BK_MAC: begin
        pv_d    = mstep_q < ipi_pkg::MSTEP_W'(ipi_pkg::MAC_STEPS);
        mstep_d = mstep_q + 1'b1;
        num_d   = num_sum;
        if (mstep_q == ipi_pkg::MSTEP_W'(ipi_pkg::MAC_STEPS)) begin
          num_d   = num_sum << 3;
          state_d = ipi_pkg::BK_DIV;
        end
      end
      ipi_pkg::BK_DIV: begin
        rem_d   = ge ? rem_diff[ipi_pkg::DIV_W-1:0] : rem_sh[ipi_pkg::DIV_W-1:0];
        num_d   = {num_q[ipi_pkg::NUM_W-2:0], ge};
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == ipi_pkg::DSTEP_W'(ipi_pkg::NUM_W - 1)) begin
          out_d   = (num_d[ipi_pkg::NUM_W-1:ipi_pkg::OUT_W] != '0) ? '1
                                                              : num_d[ipi_pkg::OUT_W-1:0];
          state_d = ipi_pkg::BK_OUT;
        end
      end
      ipi_pkg::BK_OUT: begin
        if (!out_stall_i) begin
          state_d = ipi_pkg::BK_IDLE;
        end
      end
      default: state_d = ipi_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipi_pkg::BK_IDLE;
      pv_q    <= 1'b0;
      dstep_q <= '0;
      mstep_q <= '0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      dstep_q <= dstep_d;
      mstep_q <= mstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    num_q  <= num_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    psh_q  <= psh_d;
    out_q  <= out_d;
  end

endmodule

// ===== src/ipi_checker.sv =====
// Port-level checks of the I/Q power integrator, bound to the top level.
module ipi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [ipi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [ipi_pkg::OUT_W-1:0]       average_power_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_power_o))
    else $error("stalled output beat changed");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
    (cfg_index_i == ipi_pkg::REG_INTEGRATE || cfg_index_i == ipi_pkg::REG_FFT)
    |=> !cfg_ready_o && in_stall_o)
    else $error("config write did not start ratio update");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> in_stall_o)
    else $error("input accepted during ratio update");

endmodule

bind iq_power_integrator_unit ipi_checker u_ipi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_index_i     (cfg_index_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .average_power_o (average_power_o)
);
